/* hw/rtl/pps_pkg.sv */
`timescale 1ns / 1ps

package pps_pkg;

  // result status codes
  typedef enum logic [3:0] {
    STATUS_PENDING    = 4'd0,
    STATUS_ACCEPTED   = 4'd1,
    STATUS_BAD_FIRST  = 4'd2,
    STATUS_CHECKSUM   = 4'd3,
    STATUS_FMT_BIT7   = 4'd4,
    STATUS_THIRD_BYTE = 4'd5,
    STATUS_PROTOCOL   = 4'd6,
    STATUS_BAD_FI     = 4'd7,
    STATUS_BAD_DI     = 4'd8,
    STATUS_RATE       = 4'd9
  } status_e;

  // register byte addresses
  localparam int unsigned AddrWidth = 3;
  localparam logic [AddrWidth-1:0] ADDR_FI_CODE = 3'd0;
  localparam logic [AddrWidth-1:0] ADDR_DI_CODE = 3'd4;

  localparam logic [3:0] FI_CODE_RESET = 4'd9;  // Fi 512
  localparam logic [3:0] DI_CODE_RESET = 4'd6;  // Di 32
  localparam logic [7:0] PPS_INITIAL   = 8'hff;

  typedef struct packed {
    logic [3:0] fi_code;
    logic [3:0] di_code;
  } cfg_t;

  typedef struct packed {
    status_e    status;
    logic [2:0] length;
  } result_t;

  // clock rate conversion codes with a defined Fi
  function automatic logic fi_code_valid(input logic [3:0] code);
    logic ok;
    case (code)
      4'd0, 4'd7, 4'd8, 4'd14, 4'd15: ok = 1'b0;
      default:                         ok = 1'b1;
    endcase
    return ok;
  endfunction

  // baud rate adjustment codes with a defined Di
  function automatic logic di_code_valid(input logic [3:0] code);
    logic ok;
    case (code)
      4'd0, 4'd7, 4'd8, 4'd9: ok = 1'b0;
      default:                ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

/* hw/rtl/pps_byte_if.sv */
`timescale 1ns / 1ps

interface pps_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

/* hw/rtl/pps_result_if.sv */
`timescale 1ns / 1ps

interface pps_result_if;
  logic            valid;
  logic            ready;
  pps_pkg::status_e status;
  logic [2:0]      length;

  modport source (output valid, output status, output length, input ready);
  modport sink (input valid, input status, input length, output ready);
endinterface

/* hw/rtl/pps_request_checker_top.sv */
`timescale 1ns / 1ps

// Checks a smart-card PPS request that arrives one byte per request on
// req_i and returns one result per byte on rsp_o: the status (pending until
// the request is complete or the initial byte is found wrong after three
// bytes, then a final code) and the number of bytes received so far. A final
// code clears the request state. The block sits between an input register
// and a result register, so a byte can be taken in every cycle while rsp_o
// is ready, and its result reaches rsp_o through both registers in turn.
// The accepted Fi and Di codes sit at byte addresses 0 and 4 of the APB
// port and should only be written while no request bytes are in flight.
module pps_request_checker_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pps_byte_if.sink                      req_i,
  pps_result_if.source                  rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pps_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  pps_pkg::cfg_t    cfg;
  pps_pkg::result_t result;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  pps_pkg::result_t out_q;
  logic       out_adv;
  logic       eval_fire;
  logic       in_fire;

  pps_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // pipeline advance
  assign out_adv     = !out_valid_q || rsp_o.ready;
  assign eval_fire   = in_valid_q && out_adv;
  assign req_i.ready = !in_valid_q || out_adv;
  assign in_fire     = req_i.valid && req_i.ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= req_i.rx_byte;
    end
  end

  pps_eval u_eval (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (eval_fire),
    .rx_byte_i (in_byte_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_fire) begin
      out_q <= result;
    end
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.status = out_q.status;
  assign rsp_o.length = out_q.length;

  // a bad initial byte is reported exactly at the third byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_fire && result.status == pps_pkg::STATUS_BAD_FIRST |-> result.length == 3'd3)
    else $error("bad initial byte reported at wrong length");

  // any other final status needs at least three bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_fire && result.status != pps_pkg::STATUS_PENDING |-> result.length >= 3'd3)
    else $error("final status on a short request");

  // the result count never wraps to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_fire |-> result.length != 3'd0)
    else $error("byte count wrapped");

  // input stalls only while a result is held at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> out_valid_q && in_valid_q)
    else $error("input stalled without a held result");

endmodule

/* hw/rtl/pps_cfg_regs.sv */
`timescale 1ns / 1ps

module pps_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pps_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output pps_pkg::cfg_t                 cfg_o
);

  logic          wr_en;
  pps_pkg::cfg_t cfg_q;
  pps_pkg::cfg_t cfg_d;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // word-aligned decode on the address
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      if (paddr[2] == pps_pkg::ADDR_DI_CODE[2]) begin
        cfg_d.di_code = pwdata[3:0];
      end else begin
        cfg_d.fi_code = pwdata[3:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fi_code <= pps_pkg::FI_CODE_RESET;
      cfg_q.di_code <= pps_pkg::DI_CODE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back
  always_comb begin
    if (paddr[2] == pps_pkg::ADDR_DI_CODE[2]) begin
      prdata = {28'd0, cfg_q.di_code};
    end else begin
      prdata = {28'd0, cfg_q.fi_code};
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/pps_eval.sv */
`timescale 1ns / 1ps

module pps_eval (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       rx_byte_i,
  input  pps_pkg::cfg_t    cfg_i,
  output pps_pkg::result_t result_o
);

  logic [2:0] count_q, count_d;
  logic [7:0] first_q, first_d;
  logic [7:0] format_q, format_d;
  logic [7:0] param1_q, param1_d;
  logic [7:0] xor_q, xor_d;

  logic [2:0]       len;
  logic [2:0]       expected;
  logic [3:0]       fi;
  logic [3:0]       di;
  pps_pkg::status_e status;

  // fold the new byte into the request
  always_comb begin
    len      = count_q + 3'd1;
    first_d  = (count_q == 3'd0) ? rx_byte_i : first_q;
    format_d = (count_q == 3'd1) ? rx_byte_i : format_q;
    param1_d = (count_q == 3'd2 && format_q[4]) ? rx_byte_i : param1_q;
    xor_d    = xor_q ^ rx_byte_i;
    count_d  = len;
  end

  // expected length: initial, format and check bytes plus optional ones
  assign expected = 3'd3 + {2'd0, format_d[4]} + {2'd0, format_d[5]}
                  + {2'd0, format_d[6]} + {2'd0, format_d[7]};
  assign fi = param1_d[7:4];
  assign di = param1_d[3:0];

  // status in priority order
  always_comb begin
    status = pps_pkg::STATUS_PENDING;
    if (len >= 3'd3) begin
      if (first_d != pps_pkg::PPS_INITIAL) begin
        status = pps_pkg::STATUS_BAD_FIRST;
      end else if (len >= expected) begin
        if (xor_d != 8'd0) begin
          status = pps_pkg::STATUS_CHECKSUM;
        end else if (format_d[7]) begin
          status = pps_pkg::STATUS_FMT_BIT7;
        end else if (format_d[6]) begin
          status = pps_pkg::STATUS_THIRD_BYTE;
        end else if (format_d[3:0] != 4'd0) begin
          status = pps_pkg::STATUS_PROTOCOL;
        end else if (!pps_pkg::fi_code_valid(fi)) begin
          status = pps_pkg::STATUS_BAD_FI;
        end else if (!pps_pkg::di_code_valid(di)) begin
          status = pps_pkg::STATUS_BAD_DI;
        end else if (fi != cfg_i.fi_code || di != cfg_i.di_code) begin
          status = pps_pkg::STATUS_RATE;
        end else begin
          status = pps_pkg::STATUS_ACCEPTED;
        end
      end
    end
  end

  assign result_o.status = status;
  assign result_o.length = len;

  // request state, cleared by any final status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 3'd0;
      first_q  <= 8'd0;
      format_q <= 8'd0;
      param1_q <= 8'd0;
      xor_q    <= 8'd0;
    end else if (fire_i) begin
      if (status != pps_pkg::STATUS_PENDING) begin
        count_q  <= 3'd0;
        first_q  <= 8'd0;
        format_q <= 8'd0;
        param1_q <= 8'd0;
        xor_q    <= 8'd0;
      end else begin
        count_q  <= count_d;
        first_q  <= first_d;
        format_q <= format_d;
        param1_q <= param1_d;
        xor_q    <= xor_d;
      end
    end
  end

endmodule

/* tb/pps_status_compare.sv */
`timescale 1ns / 1ps

module pps_status_compare (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pps_byte_if                           req_i,
  pps_result_if                         rsp_i,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pps_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  input  logic                          pready,
  output int unsigned                   mismatch_count_o,
  output int unsigned                   in_flight_o,
  output int unsigned                   results_o,
  output int unsigned                   finals_o,
  output int unsigned                   accepts_o
);

  // codes with a defined Fi or Di, one bit per code
  localparam logic [15:0] FiDefined = 16'b0011_1110_0111_1110;
  localparam logic [15:0] DiDefined = 16'b1111_1100_0111_1110;

  // shadow of the accepted codes and of the request being parsed
  logic [3:0] acc_fi_code;
  logic [3:0] acc_di_code;
  logic [2:0] req_count;
  logic [7:0] req_first;
  logic [7:0] req_format;
  logic [7:0] req_param1;
  logic [7:0] req_xor;

  pps_pkg::result_t predicted_status_q[$];
  pps_pkg::result_t want;

  function automatic void clear_request();
    req_count  = '0;
    req_first  = '0;
    req_format = '0;
    req_param1 = '0;
    req_xor    = '0;
  endfunction

  // next status and length for one request byte
  function automatic pps_pkg::result_t predict_status(input logic [7:0] rx);
    pps_pkg::result_t res;
    logic [2:0]       need;
    logic [3:0]       fi;
    logic [3:0]       di;
    res.status = pps_pkg::STATUS_PENDING;
    case (req_count)
      3'd0: req_first = rx;
      3'd1: req_format = rx;
      3'd2: if (req_format[4]) req_param1 = rx;
      default: ;
    endcase
    req_xor    = req_xor ^ rx;
    req_count  = req_count + 3'd1;
    res.length = req_count;
    need = 3'd3 + 3'(req_format[4]) + 3'(req_format[5]) + 3'(req_format[6])
         + 3'(req_format[7]);
    fi = req_param1[7:4];
    di = req_param1[3:0];
    if (req_count >= 3'd3) begin
      if (req_first != pps_pkg::PPS_INITIAL) begin
        res.status = pps_pkg::STATUS_BAD_FIRST;
      end else if (req_count >= need) begin
        if (req_xor != 8'h00) res.status = pps_pkg::STATUS_CHECKSUM;
        else if (req_format[7]) res.status = pps_pkg::STATUS_FMT_BIT7;
        else if (req_format[6]) res.status = pps_pkg::STATUS_THIRD_BYTE;
        else if (req_format[3:0] != 4'h0) res.status = pps_pkg::STATUS_PROTOCOL;
        else if (!FiDefined[fi]) res.status = pps_pkg::STATUS_BAD_FI;
        else if (!DiDefined[di]) res.status = pps_pkg::STATUS_BAD_DI;
        else if (fi != acc_fi_code || di != acc_di_code) res.status = pps_pkg::STATUS_RATE;
        else res.status = pps_pkg::STATUS_ACCEPTED;
      end
    end
    if (res.status != pps_pkg::STATUS_PENDING) clear_request();
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_fi_code = pps_pkg::FI_CODE_RESET;
      acc_di_code = pps_pkg::DI_CODE_RESET;
      clear_request();
      predicted_status_q.delete();
      mismatch_count_o = 0;
      in_flight_o      = 0;
      results_o        = 0;
      finals_o         = 0;
      accepts_o        = 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          pps_pkg::ADDR_FI_CODE: acc_fi_code = pwdata[3:0];
          pps_pkg::ADDR_DI_CODE: acc_di_code = pwdata[3:0];
          default: ;
        endcase
      end
      // compare a result against the oldest prediction
      if (rsp_i.valid && rsp_i.ready) begin
        results_o++;
        if (predicted_status_q.size() == 0) begin
          $error("unexpected result: status %0d length %0d", rsp_i.status, rsp_i.length);
          mismatch_count_o++;
        end else begin
          want = predicted_status_q.pop_front();
          if (rsp_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_i.status);
            mismatch_count_o++;
          end
          if (rsp_i.length !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, rsp_i.length);
            mismatch_count_o++;
          end
          if (want.status != pps_pkg::STATUS_PENDING) finals_o++;
          if (want.status == pps_pkg::STATUS_ACCEPTED) accepts_o++;
        end
      end
      // predict from each accepted request byte
      if (req_i.valid && req_i.ready) begin
        predicted_status_q.push_back(predict_status(req_i.rx_byte));
      end
      in_flight_o = predicted_status_q.size();
    end
  end

endmodule

/* tb/pps_request_checker_top_test.sv */
`timescale 1ns / 1ps

module pps_request_checker_top_test;

  localparam int unsigned RandomBytes = 1100;
  localparam int unsigned Phases      = 8;
  localparam int unsigned CycleLimit  = 200000;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [pps_pkg::AddrWidth-1:0] paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  pps_byte_if   req_if ();
  pps_result_if rsp_if ();

  int unsigned mismatches;
  int unsigned in_flight;
  int unsigned results_seen;
  int unsigned finals_seen;
  int unsigned accepts_seen;
  int unsigned bytes_sent;
  int unsigned gap_odds;
  int unsigned cycle_count = 0;
  logic [3:0]  cur_fi_code;
  logic [3:0]  cur_di_code;
  logic        byte_taken;
  logic        cfg_written;

  pps_request_checker_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pps_status_compare u_status_compare (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req_if),
    .rsp_i            (rsp_if),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .mismatch_count_o (mismatches),
    .in_flight_o      (in_flight),
    .results_o        (results_seen),
    .finals_o         (finals_seen),
    .accepts_o        (accepts_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // handshakes seen at the last rising edge, read back at the falling edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_taken  <= 1'b0;
      cfg_written <= 1'b0;
    end else begin
      byte_taken  <= req_if.valid && req_if.ready;
      cfg_written <= psel && penable && pwrite && pready;
    end
  end

  // result side back-pressure in bursts
  initial begin
    int unsigned hold;
    hold = 0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        rsp_if.ready = 1'b0;
        hold--;
      end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
        rsp_if.ready = 1'b0;
        hold = $urandom_range(0, 14);
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  // one request byte, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] value);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    req_if.valid   = 1'b1;
    req_if.rx_byte = value;
    do @(negedge clk_i); while (!byte_taken);
    bytes_sent++;
  endtask

  // full pps request, parameter bytes past the first are random
  task automatic send_request(input logic [7:0] first, input logic [7:0] format,
                              input logic [7:0] param1, input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] opt_byte;
    sum = first ^ format;
    send_byte(first);
    send_byte(format);
    for (int i = 4; i < 8; i++) begin
      if (format[i]) begin
        opt_byte = (i == 4) ? param1 : 8'($urandom);
        sum      = sum ^ opt_byte;
        send_byte(opt_byte);
      end
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  task automatic write_reg(input logic [pps_pkg::AddrWidth-1:0] addr,
                           input logic [3:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = {28'($urandom), value};
    @(negedge clk_i);
    penable = 1'b1;
    do @(negedge clk_i); while (!cfg_written);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic wait_drained();
    req_if.valid = 1'b0;
    do @(negedge clk_i); while (in_flight != 0);
  endtask

  // mostly well-formed requests, some with a wrong initial or check byte, plus noise
  task automatic random_traffic();
    logic [7:0]  format;
    logic [7:0]  param1;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
    end else begin
      format = 8'($urandom);
      if ($urandom_range(0, 3) != 0) format[3:0] = 4'h0;
      if ($urandom_range(0, 2) != 0) format[7:6] = 2'b00;
      if ($urandom_range(0, 3) != 0) format[4] = 1'b1;
      case ($urandom_range(0, 2))
        0: param1 = {cur_fi_code, cur_di_code};
        1: param1 = {4'($urandom_range(1, 6)), 4'($urandom_range(1, 6))};
        default: param1 = 8'($urandom);
      endcase
      send_request((pick < 25) ? 8'($urandom) : pps_pkg::PPS_INITIAL, format, param1,
                   $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    int unsigned directed_bytes;
    logic [3:0]  next_fi;
    logic [3:0]  next_di;
    req_if.valid   = 1'b0;
    req_if.rx_byte = 8'h00;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    gap_odds       = 0;
    bytes_sent     = 0;
    cur_fi_code    = pps_pkg::FI_CODE_RESET;
    cur_di_code    = pps_pkg::DI_CODE_RESET;
    rst_ni         = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // at least one request per status under the reset codes
    send_request(pps_pkg::PPS_INITIAL, 8'h10, 8'h96, 1'b0);  // accepted
    send_request(8'h3b, 8'h00, 8'h00, 1'b0);                 // wrong initial byte
    send_request(pps_pkg::PPS_INITIAL, 8'h00, 8'h00, 1'b1);  // bad check byte
    send_request(pps_pkg::PPS_INITIAL, 8'h80, 8'h00, 1'b0);  // format bit 7
    send_request(pps_pkg::PPS_INITIAL, 8'h40, 8'h00, 1'b0);  // third parameter byte
    send_request(pps_pkg::PPS_INITIAL, 8'h01, 8'h00, 1'b0);  // protocol other than T=0
    send_request(pps_pkg::PPS_INITIAL, 8'h00, 8'h00, 1'b0);  // first parameter byte absent
    send_request(pps_pkg::PPS_INITIAL, 8'h10, 8'hf6, 1'b0);  // undefined Fi
    send_request(pps_pkg::PPS_INITIAL, 8'h10, 8'h97, 1'b0);  // undefined Di
    send_request(pps_pkg::PPS_INITIAL, 8'h10, 8'h95, 1'b0);  // rate not the accepted one
    directed_bytes = bytes_sent;

    // random phases, each writing the codes anew and setting its idling
    for (int unsigned phase = 0; phase < Phases; phase++) begin
      wait_drained();
      case (phase)
        0: begin next_fi = 4'h0; next_di = 4'h0; end
        1: begin next_fi = 4'hf; next_di = 4'hf; end
        2: begin next_fi = 4'($urandom_range(1, 6)); next_di = 4'($urandom_range(1, 6)); end
        3: begin next_fi = 4'($urandom_range(9, 13)); next_di = 4'($urandom_range(10, 15)); end
        4, 5: begin next_fi = 4'($urandom); next_di = 4'($urandom); end
        default: begin
          next_fi = pps_pkg::FI_CODE_RESET;
          next_di = pps_pkg::DI_CODE_RESET;
        end
      endcase
      write_reg(pps_pkg::ADDR_FI_CODE, next_fi);
      write_reg(pps_pkg::ADDR_DI_CODE, next_di);
      cur_fi_code = next_fi;
      cur_di_code = next_di;
      if (phase == Phases - 1) gap_odds = 0;
      else if (phase % 3 == 1) gap_odds = 4;
      else if (phase % 3 == 2) gap_odds = 12;
      else gap_odds = 0;
      while (bytes_sent - directed_bytes < (phase + 1) * RandomBytes / Phases) begin
        random_traffic();
      end
    end

    wait_drained();
    repeat (4) @(negedge clk_i);
    $display("Sent %0d request bytes under %0d code settings, idling on and off",
             bytes_sent, Phases + 1);
    $display("Checked %0d results: %0d final statuses, %0d accepted requests",
             results_seen, finals_seen, accepts_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
